FILE: sv/gs27_pkg.sv
package gs27_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_WEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_WEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_WEIGHT = 3'd6;

    // size register width and reset values
    localparam int SIZE_W = 7;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam int CENTER_RESET = 32768;
    localparam int FACE_RESET   = 16384;
    localparam int EDGE_RESET   = 8192;
    localparam int CORNER_RESET = 4096;

    // result queue
    localparam int FQ_DEPTH = 8;
    localparam int FQ_AW    = 3;

    // tap classes by number of off-center axes
    typedef logic [1:0] tap_class_t;
    localparam tap_class_t TAP_CENTER = 2'd0;
    localparam tap_class_t TAP_FACE   = 2'd1;
    localparam tap_class_t TAP_EDGE   = 2'd2;
    localparam tap_class_t TAP_CORNER = 2'd3;

    // window index k = t*9 + dx*3 + dy, each 0..2 with 1 the center
    function automatic tap_class_t tap_class(input int k);
        int off;
        off = 0;
        if ((k / 9) != 1) off = off + 1;
        if (((k / 3) % 3) != 1) off = off + 1;
        if ((k % 3) != 1) off = off + 1;
        return tap_class_t'(off);
    endfunction

endpackage

FILE: sv/grid_smooth_27_point.sv
// Weighted 27-point 3D smoother. Takes a halo-padded grid of
// (size_x+2) x (size_y+2) x (size_z+2) samples, z fastest, and returns one
// saturated weighted sum per interior point in the same order, with tlast on
// the final point of the grid. One sample is taken every clock cycle; a result
// is offered on the output once the sample that completes its neighborhood
// has passed the window, sum, product and total stages and the result queue.
// Sustained rate is one sample per cycle, set by the single read-modify-write
// of the plane memory (two samples per y,z entry) and of the line memory (six
// samples per z entry) done for each sample. The stores need no clearing pass:
// after a reset or a size change a new grid simply starts at position zero.
// Input is stalled only when eight results are outstanding in the pipeline
// and the output queue together.
module grid_smooth_27_point #(
    parameter int MAX_X       = 64,
    parameter int MAX_Y       = 64,
    parameter int MAX_Z       = 64,
    parameter int SAMPLE_BITS = 24,
    parameter int WEIGHT_BITS = 18
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // padded_sample
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,   // smoothed_sample
    output logic                                   m_tlast,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [gs27_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  logic [WEIGHT_BITS-1:0]                 cfg_wdata
);

    localparam int SB        = SAMPLE_BITS;
    localparam int WB        = WEIGHT_BITS;
    localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ROW_LEN   = MAX_Z + 2;
    localparam int PLANE_LEN = (MAX_Y + 2) * ROW_LEN;
    localparam int PX_W      = $clog2(MAX_X + 3);
    localparam int PY_W      = $clog2(MAX_Y + 3);
    localparam int PZ_W      = $clog2(MAX_Z + 3);
    localparam int PA_W      = $clog2(PLANE_LEN);
    localparam int LA_W      = $clog2(ROW_LEN);
    localparam int ACC_W     = SB + WB + 6;
    localparam int SW        = gs27_pkg::SIZE_W;
    localparam int FQ_AW     = gs27_pkg::FQ_AW;
    localparam int CNT_W     = gs27_pkg::FQ_AW + 1;

    localparam logic signed [ACC_W-1:0] SMAX  = (ACC_W'(1) << (SB - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMIN  = -SMAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (WB - 1);

    // configuration registers
    logic [SW-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [WB-1:0] center_w_reg, face_w_reg, edge_w_reg, corner_w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg   <= gs27_pkg::SIZE_RESET;
            size_y_reg   <= gs27_pkg::SIZE_RESET;
            size_z_reg   <= gs27_pkg::SIZE_RESET;
            center_w_reg <= WB'(gs27_pkg::CENTER_RESET);
            face_w_reg   <= WB'(gs27_pkg::FACE_RESET);
            edge_w_reg   <= WB'(gs27_pkg::EDGE_RESET);
            corner_w_reg <= WB'(gs27_pkg::CORNER_RESET);
        end else if (cfg_we) begin
            case (cfg_idx)
                gs27_pkg::CFG_SIZE_X:        size_x_reg   <= cfg_wdata[SW-1:0];
                gs27_pkg::CFG_SIZE_Y:        size_y_reg   <= cfg_wdata[SW-1:0];
                gs27_pkg::CFG_SIZE_Z:        size_z_reg   <= cfg_wdata[SW-1:0];
                gs27_pkg::CFG_CENTER_WEIGHT: center_w_reg <= cfg_wdata;
                gs27_pkg::CFG_FACE_WEIGHT:   face_w_reg   <= cfg_wdata;
                gs27_pkg::CFG_EDGE_WEIGHT:   edge_w_reg   <= cfg_wdata;
                gs27_pkg::CFG_CORNER_WEIGHT: corner_w_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // padded extents, size clamped to 1..MAX
    logic [PX_W-1:0] ext_x;
    logic [PY_W-1:0] ext_y;
    logic [PZ_W-1:0] ext_z;

    always_comb begin
        if (size_x_reg == '0) ext_x = PX_W'(3);
        else if (int'(size_x_reg) > MAX_X) ext_x = PX_W'(MAX_X + 2);
        else ext_x = PX_W'(size_x_reg) + PX_W'(2);
        if (size_y_reg == '0) ext_y = PY_W'(3);
        else if (int'(size_y_reg) > MAX_Y) ext_y = PY_W'(MAX_Y + 2);
        else ext_y = PY_W'(size_y_reg) + PY_W'(2);
        if (size_z_reg == '0) ext_z = PZ_W'(3);
        else if (int'(size_z_reg) > MAX_Z) ext_z = PZ_W'(MAX_Z + 2);
        else ext_z = PZ_W'(size_z_reg) + PZ_W'(2);
    end

    // handshake and outstanding-result credit
    logic             in_xfer, out_xfer;
    logic [CNT_W-1:0] pending_reg, pending_next;
    logic [CNT_W-1:0] fq_count_reg;
    logic             emit_now, last_now;

    assign s_tready = (pending_reg < CNT_W'(gs27_pkg::FQ_DEPTH));
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = (fq_count_reg != '0);
    assign out_xfer = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (in_xfer && emit_now) pending_next = pending_next + CNT_W'(1);
        if (out_xfer) pending_next = pending_next - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) pending_reg <= '0;
        else pending_reg <= pending_next;
    end

    // padded position of the next sample
    logic [PX_W-1:0] pos_x_reg, pos_x_next;
    logic [PY_W-1:0] pos_y_reg, pos_y_next;
    logic [PZ_W-1:0] pos_z_reg, pos_z_next;
    logic [PA_W-1:0] row_base_reg, row_base_next;
    logic            z_wrap, y_wrap, x_wrap;

    assign z_wrap = ({1'b0, pos_z_reg} + (PZ_W+1)'(1)) >= {1'b0, ext_z};
    assign y_wrap = ({1'b0, pos_y_reg} + (PY_W+1)'(1)) >= {1'b0, ext_y};
    assign x_wrap = ({1'b0, pos_x_reg} + (PX_W+1)'(1)) >= {1'b0, ext_x};

    assign emit_now = (pos_x_reg >= PX_W'(2)) && (pos_y_reg >= PY_W'(2)) &&
                      (pos_z_reg >= PZ_W'(2));
    assign last_now = (pos_x_reg == ext_x - PX_W'(1)) && (pos_y_reg == ext_y - PY_W'(1)) &&
                      (pos_z_reg == ext_z - PZ_W'(1));

    always_comb begin
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pos_z_next    = pos_z_reg + PZ_W'(1);
        row_base_next = row_base_reg;
        if (z_wrap) begin
            pos_z_next = '0;
            if (y_wrap) begin
                pos_y_next    = '0;
                row_base_next = '0;
                pos_x_next    = x_wrap ? '0 : pos_x_reg + PX_W'(1);
            end else begin
                pos_y_next    = pos_y_reg + PY_W'(1);
                row_base_next = row_base_reg + PA_W'(ROW_LEN);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            row_base_reg <= '0;
        end else if (in_xfer) begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            pos_z_reg    <= pos_z_next;
            row_base_reg <= row_base_next;
        end
    end

    logic [PA_W-1:0] plane_addr;
    logic [LA_W-1:0] line_addr;
    assign plane_addr = row_base_reg + PA_W'(pos_z_reg);
    assign line_addr  = pos_z_reg[LA_W-1:0];

    // stage 1: sample and addresses alongside the memory read
    logic            v1_reg, emit1_reg, last1_reg;
    logic [SB-1:0]   samp1_reg;
    logic [PA_W-1:0] pa1_reg;
    logic [LA_W-1:0] la1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= in_xfer;
        end
        emit1_reg <= emit_now;
        last1_reg <= last_now;
        samp1_reg <= s_tdata[SB-1:0];
        pa1_reg   <= plane_addr;
        la1_reg   <= line_addr;
    end

    // plane memory: per (y,z) the samples of planes x-1 (low) and x-2 (high)
    // line memory: per z, six samples of lines y-1 and y-2 for the three planes
    logic [2*SB-1:0] plane_mem [PLANE_LEN];
    logic [6*SB-1:0] line_mem  [ROW_LEN];
    logic [2*SB-1:0] plane_rd_reg;
    logic [6*SB-1:0] line_rd_reg;
    logic [2*SB-1:0] plane_wr;
    logic [6*SB-1:0] line_wr;

    // each entry recurs no sooner than three samples later, so the write
    // in the cycle after the read never races the next read of that entry
    always_ff @(posedge aclk) begin
        if (in_xfer) plane_rd_reg <= plane_mem[plane_addr];
        if (v1_reg) plane_mem[pa1_reg] <= plane_wr;
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) line_rd_reg <= line_mem[line_addr];
        if (v1_reg) line_mem[la1_reg] <= line_wr;
    end

    // column of nine taps: index dx*3+dy, 0 = oldest
    logic signed [SB-1:0] col [9];

    always_comb begin
        col[0] = line_rd_reg[0*SB +: SB];
        col[1] = line_rd_reg[1*SB +: SB];
        col[2] = plane_rd_reg[SB +: SB];
        col[3] = line_rd_reg[2*SB +: SB];
        col[4] = line_rd_reg[3*SB +: SB];
        col[5] = plane_rd_reg[0 +: SB];
        col[6] = line_rd_reg[4*SB +: SB];
        col[7] = line_rd_reg[5*SB +: SB];
        col[8] = samp1_reg;
        plane_wr = {plane_rd_reg[0 +: SB], samp1_reg};
        line_wr  = {samp1_reg, line_rd_reg[5*SB +: SB], plane_rd_reg[0 +: SB],
                    line_rd_reg[3*SB +: SB], plane_rd_reg[SB +: SB],
                    line_rd_reg[1*SB +: SB]};
    end

    // stage 2: 3x3x3 window, shifted by one column per sample
    logic signed [SB-1:0] win_reg [27];
    logic                 v2_reg, last2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 27; k++) win_reg[k] <= '0;
            v2_reg <= 1'b0;
        end else begin
            if (v1_reg) begin
                for (int k = 0; k < 18; k++) win_reg[k] <= win_reg[k+9];
                for (int i = 0; i < 9; i++) win_reg[18+i] <= col[i];
            end
            v2_reg <= v1_reg && emit1_reg;
        end
        last2_reg <= last1_reg;
    end

    // stage 3: sums per tap class
    logic signed [SB+3:0] face_sum, edge_sum, corner_sum;
    logic signed [SB-1:0] cen3_reg;
    logic signed [SB+3:0] face3_reg, edge3_reg, corner3_reg;
    logic                 v3_reg, last3_reg;

    always_comb begin
        face_sum   = '0;
        edge_sum   = '0;
        corner_sum = '0;
        for (int k = 0; k < 27; k++) begin
            case (gs27_pkg::tap_class(k))
                gs27_pkg::TAP_FACE:   face_sum   = face_sum + (SB+4)'(win_reg[k]);
                gs27_pkg::TAP_EDGE:   edge_sum   = edge_sum + (SB+4)'(win_reg[k]);
                gs27_pkg::TAP_CORNER: corner_sum = corner_sum + (SB+4)'(win_reg[k]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else v3_reg <= v2_reg;
        cen3_reg    <= win_reg[13];
        face3_reg   <= face_sum;
        edge3_reg   <= edge_sum;
        corner3_reg <= corner_sum;
        last3_reg   <= last2_reg;
    end

    // stage 4: one product per class
    logic signed [ACC_W-1:0] pc4_reg, pf4_reg, pe4_reg, pk4_reg;
    logic                    v4_reg, last4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else v4_reg <= v3_reg;
        pc4_reg   <= cen3_reg * $signed({1'b0, center_w_reg});
        pf4_reg   <= face3_reg * $signed({1'b0, face_w_reg});
        pe4_reg   <= edge3_reg * $signed({1'b0, edge_w_reg});
        pk4_reg   <= corner3_reg * $signed({1'b0, corner_w_reg});
        last4_reg <= last3_reg;
    end

    // stage 5: total plus rounding offset
    logic signed [ACC_W-1:0] acc5_reg;
    logic                    v5_reg, last5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else v5_reg <= v4_reg;
        acc5_reg  <= pc4_reg + pf4_reg + pe4_reg + pk4_reg + ROUND;
        last5_reg <= last4_reg;
    end

    // floor shift and saturate
    logic signed [ACC_W-1:0] shifted;
    logic [SB-1:0]           result;

    always_comb begin
        shifted = acc5_reg >>> WB;
        if (shifted > SMAX) result = SMAX[SB-1:0];
        else if (shifted < SMIN) result = SMIN[SB-1:0];
        else result = shifted[SB-1:0];
    end

    // result queue
    logic [SB-1:0]    fq_data [gs27_pkg::FQ_DEPTH];
    logic             fq_last [gs27_pkg::FQ_DEPTH];
    logic [FQ_AW-1:0] fq_wr_reg, fq_rd_reg;

    always_ff @(posedge aclk) begin
        if (v5_reg) begin
            fq_data[fq_wr_reg] <= result;
            fq_last[fq_wr_reg] <= last5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fq_wr_reg    <= '0;
            fq_rd_reg    <= '0;
            fq_count_reg <= '0;
        end else begin
            if (v5_reg) fq_wr_reg <= fq_wr_reg + FQ_AW'(1);
            if (out_xfer) fq_rd_reg <= fq_rd_reg + FQ_AW'(1);
            case ({v5_reg, out_xfer})
                2'b10:   fq_count_reg <= fq_count_reg + CNT_W'(1);
                2'b01:   fq_count_reg <= fq_count_reg - CNT_W'(1);
                default: fq_count_reg <= fq_count_reg;
            endcase
        end
    end

    assign m_tdata = TDATA_W'(fq_data[fq_rd_reg]);
    assign m_tlast = fq_last[fq_rd_reg];

    // credit never exceeds the queue depth
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= CNT_W'(gs27_pkg::FQ_DEPTH))
        else $error("pending results exceed queue depth");

    // queued results are always covered by credit
    a_queue_le_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fq_count_reg <= pending_reg)
        else $error("queue holds more than outstanding results");

    // a queue write never lands on a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg |-> (fq_count_reg < CNT_W'(gs27_pkg::FQ_DEPTH)))
        else $error("result queue overflow");

    // an emitting transfer always reaches the queue write stage
    a_emit_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && emit_now) |-> ##5 v5_reg)
        else $error("result lost in pipeline");

endmodule
